/* hdl/bbhpw_pkg.sv */
// ----------------------------------------------------------------------------
// bbhpw_pkg
// Shared types and constants for the hi-res pixel writer: link tags, page
// decode constants and the write command passed from front to back.
// ----------------------------------------------------------------------------
package bbhpw_pkg;

  typedef enum logic [1:0] {
    TAG_ADDR_HIGH = 2'd0,
    TAG_ADDR_MID  = 2'd1,
    TAG_ADDR_LOW  = 2'd2,
    TAG_DATA_WR   = 2'd3
  } link_tag_t;

  localparam logic [2:0] PAGE_TOP   = 3'b001;  // address bits 15..13 of 0x2000
  localparam logic [6:0] ROW_LAST   = 7'd119;
  localparam logic [6:0] GROUP_W    = 7'd40;
  localparam logic [6:0] GROUP_W2   = 7'd80;
  localparam int         PIXELS     = 7;
  localparam int         QUEUE_DEPTH_DEF = 4;

  // One decoded write: first column, screen line and the seven shown bits.
  typedef struct packed {
    logic [8:0] base_x;
    logic [7:0] line;
    logic [6:0] data;
  } wr_cmd_t;

endpackage

/* hdl/bbhpw_front.sv */
// ----------------------------------------------------------------------------
// bbhpw_front
// Assembles the bus address and data from tagged link bytes and decodes each
// completed write that lands on a visible hi-res byte into a write command.
// ----------------------------------------------------------------------------
module bbhpw_front import bbhpw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       link_valid,
  output logic       link_stall,
  input  logic [7:0] link_byte,
  output logic       cmd_valid,
  input  logic       cmd_stall,
  output wr_cmd_t    cmd
);

  logic [15:0] bus_address;
  logic [15:0] bus_address_next;
  // Data bits 5..0 are always zero between writes, so only bit 6 is kept.
  logic        bus_data6;
  logic        bus_data6_next;
  logic        accept;
  link_tag_t   tag;
  logic [5:0]  payload;
  logic [6:0]  offset;
  logic [6:0]  column;
  logic [1:0]  group;
  logic        hit;

  assign link_stall = cmd_stall;
  assign accept     = link_valid && !link_stall;
  assign tag        = link_tag_t'(link_byte[7:6]);
  assign payload    = link_byte[5:0];
  assign offset     = bus_address[6:0];

  always_comb begin
    if (offset >= GROUP_W2) begin
      group  = 2'd2;
      column = offset - GROUP_W2;
    end else if (offset >= GROUP_W) begin
      group  = 2'd1;
      column = offset - GROUP_W;
    end else begin
      group  = 2'd0;
      column = offset;
    end
  end

  assign hit = (bus_address[15:13] == PAGE_TOP) && (offset <= ROW_LAST);

  assign cmd_valid   = link_valid && (tag == TAG_DATA_WR) && hit;
  assign cmd.base_x  = {column[5:0], 3'b000} - {3'b000, column[5:0]};
  assign cmd.line    = {group[1:0], bus_address[9:7], bus_address[12:10]};
  assign cmd.data    = {bus_data6, payload};

  always_comb begin
    bus_address_next = bus_address;
    bus_data6_next   = bus_data6;
    unique case (tag)
      TAG_ADDR_HIGH: bus_address_next = {payload, 10'd0};
      TAG_ADDR_MID:  bus_address_next = bus_address | {6'd0, payload, 4'd0};
      TAG_ADDR_LOW: begin
        bus_address_next = bus_address | {12'd0, payload[5:2]};
        bus_data6_next   = payload[0];
      end
      TAG_DATA_WR: begin
        bus_address_next = {bus_address[15:4], 4'd0};
        bus_data6_next   = 1'b0;
      end
      default: bus_address_next = bus_address;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_address <= '0;
      bus_data6   <= 1'b0;
    end else if (accept) begin
      bus_address <= bus_address_next;
      bus_data6   <= bus_data6_next;
    end
  end

endmodule

/* hdl/bbhpw_queue.sv */
// ----------------------------------------------------------------------------
// bbhpw_queue
// Small first-in first-out queue of write commands between front and back.
// ----------------------------------------------------------------------------
module bbhpw_queue import bbhpw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  wr_cmd_t in_cmd,
  output logic    out_valid,
  input  logic    out_stall,
  output wr_cmd_t out_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  wr_cmd_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_stall  = (count == CNT_FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/bbhpw_back.sv */
// ----------------------------------------------------------------------------
// bbhpw_back
// Expands each write command into seven pixel requests, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module bbhpw_back import bbhpw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  wr_cmd_t    cmd,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output logic [8:0] pixel_x,
  output logic [7:0] pixel_y,
  output logic       pixel_lit,
  output logic       last_pixel
);

  localparam int IW = $clog2(PIXELS);
  localparam logic [IW-1:0] IDX_LAST = IW'(PIXELS - 1);

  logic          busy;
  logic [IW-1:0] idx;
  logic [8:0]    cur_x;
  logic [7:0]    cur_y;
  logic [6:0]    bits;
  logic          advance;
  logic          take;

  // A pixel moves to the output stage whenever that stage is free or drains.
  assign advance   = busy && (!pixel_valid || !pixel_stall);
  assign take      = cmd_valid && (!busy || (advance && idx == IDX_LAST));
  assign cmd_stall = !(!busy || (advance && idx == IDX_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (advance) begin
      busy <= (idx != IDX_LAST);
      idx  <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_x <= cmd.base_x;
      cur_y <= cmd.line;
      bits  <= cmd.data;
    end else if (advance) begin
      cur_x <= cur_x + 9'd1;
      bits  <= {1'b0, bits[6:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || !pixel_stall) begin
      pixel_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_x    <= cur_x;
      pixel_y    <= cur_y;
      pixel_lit  <= bits[0];
      last_pixel <= (idx == IDX_LAST);
    end
  end

endmodule

/* hdl/bus_byte_to_hires_pixel_writer.sv */
// ----------------------------------------------------------------------------
// bus_byte_to_hires_pixel_writer
// Tagged link bytes in, hi-res framebuffer pixel requests out.
// ----------------------------------------------------------------------------
// The block takes one link byte per cycle while its command queue has room.
// Tag bytes build a bus address and data byte; a completed write to a visible
// hi-res byte becomes a command that waits in a QUEUE_DEPTH entry queue. The
// back end turns each command into seven pixel requests, one per cycle while
// the output is not stalled, so a write costs output time and other bytes
// cost none; the pixel expander sets the sustained rate. The command from a
// completing byte is queued, taken into the expander and then registered.
module bus_byte_to_hires_pixel_writer import bbhpw_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       link_valid,
  output logic       link_stall,
  input  logic [7:0] link_byte,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output logic [8:0] pixel_x,
  output logic [7:0] pixel_y,
  output logic       pixel_lit,
  output logic       last_pixel
);

  logic    fq_valid;
  logic    fq_stall;
  wr_cmd_t fq_cmd;
  logic    qb_valid;
  logic    qb_stall;
  wr_cmd_t qb_cmd;

  bbhpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .link_valid (link_valid),
    .link_stall (link_stall),
    .link_byte  (link_byte),
    .cmd_valid  (fq_valid),
    .cmd_stall  (fq_stall),
    .cmd        (fq_cmd)
  );

  bbhpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_stall  (fq_stall),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_stall (qb_stall),
    .out_cmd   (qb_cmd)
  );

  bbhpw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (qb_valid),
    .cmd_stall   (qb_stall),
    .cmd         (qb_cmd),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_lit   (pixel_lit),
    .last_pixel  (last_pixel)
  );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tagged-byte hi-res pixel writer. A queue-fed
// driver sends link bytes, a predictor decodes each accepted byte into the
// pixels it should cause, and a monitor checks every pixel request in order.
// Both sides idle and stall at random; one long output hold and one drain
// pause are included.
// ----------------------------------------------------------------------------
module tb_top import bbhpw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 100;

  typedef struct packed {
    logic       pause;
    logic [7:0] value;
  } link_item_t;

  typedef struct packed {
    logic [8:0] px_x;
    logic [7:0] px_y;
    logic       px_lit;
    logic       px_last;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       link_valid = 1'b0;
  logic       link_stall;
  logic [7:0] link_byte = 8'd0;
  logic       pixel_valid;
  logic       pixel_stall = 1'b0;
  logic [8:0] pixel_x;
  logic [7:0] pixel_y;
  logic       pixel_lit;
  logic       last_pixel;

  link_item_t link_queue[$];
  pixel_t     pixel_expect_q[$];

  // Predictor copy of the bus registers.
  logic [15:0] bus_addr = 16'd0;
  logic [7:0]  bus_dat = 8'd0;

  int         bytes_sent = 0;
  int         visible_writes = 0;
  int         pixels_seen = 0;
  int         errors = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;
  link_item_t drv_item;
  pixel_t     got_px;
  pixel_t     want_px;

  always #4 clk = ~clk;

  bus_byte_to_hires_pixel_writer u_dut (
    .clk        (clk),
    .rst        (rst),
    .link_valid (link_valid),
    .link_stall (link_stall),
    .link_byte  (link_byte),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_lit  (pixel_lit),
    .last_pixel (last_pixel)
  );

  // Updates the bus registers for one accepted byte and queues the pixels
  // that a completed visible write produces.
  function automatic void decode_link_byte(input logic [7:0] value);
    link_tag_t  tag;
    logic [5:0] payload;
    logic [6:0] offset;
    int         line;
    int         column;
    pixel_t     px;
    tag = link_tag_t'(value[7:6]);
    payload = value[5:0];
    case (tag)
      TAG_ADDR_HIGH: bus_addr = {payload, 10'd0};
      TAG_ADDR_MID:  bus_addr = bus_addr | {6'd0, payload, 4'd0};
      TAG_ADDR_LOW: begin
        bus_addr = bus_addr | {12'd0, payload[5:2]};
        bus_dat = {payload[1:0], 6'd0};
      end
      default: begin
        bus_dat = bus_dat | {2'd0, payload};
        offset = bus_addr[6:0];
        if (bus_addr[15:13] == PAGE_TOP && offset <= ROW_LAST) begin
          visible_writes++;
          column = int'(offset) % int'(GROUP_W);
          line = (int'(offset) / int'(GROUP_W)) * 64 + int'(bus_addr[9:7]) * 8
                 + int'(bus_addr[12:10]);
          for (int i = 0; i < PIXELS; i++) begin
            px.px_x = 9'(column * 7 + i);
            px.px_y = 8'(line);
            px.px_lit = bus_dat[i];
            px.px_last = (i == PIXELS - 1);
            pixel_expect_q.push_back(px);
          end
        end
        bus_addr = bus_addr & 16'hFFF0;
        bus_dat = 8'd0;
      end
    endcase
  endfunction

  task automatic push_byte(input link_tag_t tag, input logic [5:0] payload);
    link_queue.push_back({1'b0, tag, payload});
  endtask

  task automatic push_write(input logic [15:0] addr, input logic [7:0] data);
    push_byte(TAG_ADDR_HIGH, addr[15:10]);
    push_byte(TAG_ADDR_MID, addr[9:4]);
    push_byte(TAG_ADDR_LOW, {addr[3:0], data[7:6]});
    push_byte(TAG_DATA_WR, data[5:0]);
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Link driver: a request stays up until accepted; a pause entry holds the
  // link idle until every predicted pixel has been seen.
  always @(posedge clk) begin
    if (rst) begin
      link_valid <= 1'b0;
    end else begin
      if (link_valid && !link_stall) begin
        decode_link_byte(link_byte);
        bytes_sent++;
      end
      if (!link_valid || !link_stall) begin
        if (link_queue.size() == 0) begin
          link_valid <= 1'b0;
        end else if (link_queue[0].pause) begin
          link_valid <= 1'b0;
          if (pixel_expect_q.size() == 0) void'(link_queue.pop_front());
        end else if (hold_left == 0 && !(bytes_sent >= 60 && bytes_sent < 100)
                     && $urandom_range(99) < 32) begin
          link_valid <= 1'b0;
        end else begin
          drv_item = link_queue.pop_front();
          link_valid <= 1'b1;
          link_byte <= drv_item.value;
        end
      end
    end
  end

  // Pixel monitor and output stall control.
  always @(posedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        pixels_seen++;
        got_px = {pixel_x, pixel_y, pixel_lit, last_pixel};
        if (pixel_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel x=%0d y=%0d lit=%0b last=%0b",
                                    pixel_x, pixel_y, pixel_lit, last_pixel));
        end else begin
          want_px = pixel_expect_q.pop_front();
          if (got_px.px_x !== want_px.px_x || got_px.px_y !== want_px.px_y ||
              got_px.px_lit !== want_px.px_lit || got_px.px_last !== want_px.px_last)
            report_mismatch($sformatf(
              "pixel exp x=%0d y=%0d lit=%0b last=%0b got x=%0d y=%0d lit=%0b last=%0b",
              want_px.px_x, want_px.px_y, want_px.px_lit, want_px.px_last,
              got_px.px_x, got_px.px_y, got_px.px_lit, got_px.px_last));
        end
      end
      // One long hold-off once the random traffic is flowing.
      if (!hold_done && pixels_seen >= 42) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pixel_stall <= 1'b1;
        hold_left--;
      end else if (pixels_seen >= 120 && pixels_seen < 220) begin
        pixel_stall <= 1'b0;
      end else begin
        pixel_stall <= ($urandom_range(99) < 32);
      end
    end
  end

  // Watchdog on cycles with no request accepted on either side.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((link_valid && !link_stall) || (pixel_valid && !pixel_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no progress for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;

    // Directed: a bare data tag after reset, page corners, row slack,
    // an out-of-page write, data bit seven, and a mid-only address update.
    push_byte(TAG_DATA_WR, 6'h3F);
    push_write(16'h2000, 8'hFF);
    push_byte(TAG_ADDR_MID, 6'h01);
    push_byte(TAG_DATA_WR, 6'h15);
    push_write(16'h3FF7, 8'h80);
    push_write(16'h2078, 8'h55);
    push_write(16'h207F, 8'h2A);
    push_write(16'hFFFF, 8'hFF);
    link_queue.push_back({1'b1, 8'd0});

    while (link_queue.size() < 181) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        push_write({PAGE_TOP, 13'($urandom)}, 8'($urandom));
      end else if (pick < 85) begin
        push_write(16'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        // Partial sequence that reuses the upper address bits.
        push_byte(TAG_ADDR_MID, 6'($urandom));
        push_byte(TAG_ADDR_LOW, 6'($urandom));
        push_byte(TAG_DATA_WR, 6'($urandom));
      end else begin
        link_queue.push_back({1'b0, 8'($urandom)});
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (link_queue.size() != 0 || link_valid) @(posedge clk);
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d link bytes, %0d visible writes and %0d pixel requests,",
             bytes_sent, visible_writes, pixels_seen);
    $display("with random gaps on both sides, one long output hold and one drain pause.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
